// ----- rtl/wtcm_pkg.sv -----
// ----------------------------------------------------------------------------
// wtcm_pkg
// Shared types, register codes and defaults of the wall texture column mapper.
// ----------------------------------------------------------------------------
package wtcm_pkg;

  // default parameter values
  localparam int STEP_FRAC_BITS_DEF = 16;
  localparam int MAX_ROWS_DEF       = 2048;

  // largest texture height exponent
  localparam logic [3:0] TEX_LOG2_MAX = 4'd10;

  // configuration register codes
  typedef enum logic [2:0] {
    CFG_SCREEN_HEIGHT   = 3'd0,
    CFG_TEX_WIDTH       = 3'd1,
    CFG_TEX_HEIGHT_LOG2 = 3'd2,
    CFG_LINE_BYTES      = 3'd3,
    CFG_BYTES_PER_PIXEL = 3'd4
  } cfg_index_t;

  // input transaction
  typedef struct packed {
    logic [10:0] row;
    logic [11:0] column;
    logic [15:0] wall_frac;
    logic        wall_side;
    logic        ray_x_positive;
    logic        ray_y_negative;
    logic [15:0] line_height;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [9:0]  tex_col;
    logic [9:0]  tex_row;
    logic [19:0] texel_index;
    logic [27:0] pixel_address;
  } out_t;

  // fields carried along the divider chain
  typedef struct packed {
    logic [9:0]  tex_col;
    logic [27:0] pixel_address;
    logic [15:0] off_pos;
    logic [15:0] line_height;
  } item_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [11:0] screen_height;
    logic [10:0] tex_width;
    logic [3:0]  tex_log2;
    logic [15:0] line_bytes;
    logic [2:0]  bytes_per_pixel;
  } cfg_t;

endpackage

// ----- rtl/wall_texture_column_mapper_core.sv -----
// ----------------------------------------------------------------------------
// wall_texture_column_mapper_core
// Maps one wall slice pixel per transaction to texel and framebuffer address.
// ----------------------------------------------------------------------------
// Channels: in_valid/in_ready/in_data carry one pixel; out_valid/out_ready/
// out_data carry its result; cfg_valid/cfg_ready/cfg_index/cfg_data write the
// five registers (screen height, texture width, height exponent, line bytes,
// bytes per pixel). cfg_ready is always high; unknown indexes are ignored.
// Stages: 1 input stage, STEP_FRAC_BITS + 11 divider cells, 3 product stages.
// Throughput: one transaction per cycle while the output is not stalled, set by
// the chain of division cells, each of which yields one quotient bit of the row
// step and passes the item on.
// Each stage holds its item when the next is full and stalled, so bubbles
// close up and input is still taken while a result waits at the output.
// Reset: the pipeline empties and the registers return to 480, 64, 6, 2560
// and 4. A stalled receiver holds out_data steady until it is taken.
// Registers are to be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module wall_texture_column_mapper_core #(
  parameter int STEP_FRAC_BITS = wtcm_pkg::STEP_FRAC_BITS_DEF,
  parameter int MAX_ROWS       = wtcm_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wtcm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output wtcm_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  localparam int QW = STEP_FRAC_BITS + 11;

  logic [11:0] screen_height;
  logic [10:0] tex_width;
  logic [3:0]  tex_height_log2;
  logic [15:0] line_bytes;
  logic [2:0]  bytes_per_pixel;
  wtcm_pkg::cfg_t cfg;

  logic              ch_valid [QW+1];
  logic              ch_ready [QW+1];
  wtcm_pkg::item_t   ch_data  [QW+1];
  logic [15:0]       ch_rem   [QW+1];
  logic [QW-1:0]     ch_quo   [QW+1];

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height   <= 12'd480;
      tex_width       <= 11'd64;
      tex_height_log2 <= 4'd6;
      line_bytes      <= 16'd2560;
      bytes_per_pixel <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (wtcm_pkg::cfg_index_t'(cfg_index))
        wtcm_pkg::CFG_SCREEN_HEIGHT:   screen_height   <= cfg_data[11:0];
        wtcm_pkg::CFG_TEX_WIDTH:       tex_width       <= cfg_data[10:0];
        wtcm_pkg::CFG_TEX_HEIGHT_LOG2: tex_height_log2 <= cfg_data[3:0];
        wtcm_pkg::CFG_LINE_BYTES:      line_bytes      <= cfg_data;
        wtcm_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // saturated height exponent
  always_comb begin
    cfg.screen_height   = screen_height;
    cfg.tex_width       = tex_width;
    cfg.tex_log2        = (tex_height_log2 > wtcm_pkg::TEX_LOG2_MAX) ?
                          wtcm_pkg::TEX_LOG2_MAX : tex_height_log2;
    cfg.line_bytes      = line_bytes;
    cfg.bytes_per_pixel = bytes_per_pixel;
  end

  wtcm_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_data  (ch_data[0])
  );

  assign ch_rem[0] = 16'd0;
  assign ch_quo[0] = '0;

  // chain of division cells, most significant quotient bit first
  for (genvar j = 0; j < QW; j++) begin : g_cell
    wtcm_div_cell #(
      .QW        (QW),
      .BIT_POS   (QW - 1 - j),
      .FRAC_BITS (STEP_FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tex_log2 (cfg.tex_log2),
      .up_valid (ch_valid[j]),
      .up_ready (ch_ready[j]),
      .up_data  (ch_data[j]),
      .up_rem   (ch_rem[j]),
      .up_quo   (ch_quo[j]),
      .dn_valid (ch_valid[j+1]),
      .dn_ready (ch_ready[j+1]),
      .dn_data  (ch_data[j+1]),
      .dn_rem   (ch_rem[j+1]),
      .dn_quo   (ch_quo[j+1])
    );
  end

  wtcm_back #(.QW(QW), .FRAC_BITS(STEP_FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (ch_valid[QW]),
    .up_ready (ch_ready[QW]),
    .up_data  (ch_data[QW]),
    .up_quo   (ch_quo[QW]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  logic [15:0] unused_rem;
  assign unused_rem = ch_rem[QW];

`ifndef SYNTHESIS
  // texture row never exceeds the texture height
  a_row_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.tex_row >> cfg.tex_log2) == 10'd0)
    else $error("tex_row beyond texture height");

  // zero texture width gives column zero
  a_col_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tex_width == 11'd0) |-> out_data.tex_col == 10'd0)
    else $error("tex_col not zero for zero texture width");

  // the first cell never holds a remainder at or above the slice height
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ch_valid[1] |-> ch_rem[1] < ch_data[1].line_height)
    else $error("division remainder out of range");

  // a full output that is not taken blocks the last stage
  a_back_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped under stall");
`endif

endmodule

// ----- rtl/wtcm_front.sv -----
// ----------------------------------------------------------------------------
// wtcm_front
// Input stage: clamps, texture column with flip, row offset, byte address.
// ----------------------------------------------------------------------------
module wtcm_front #(
  parameter int MAX_ROWS = wtcm_pkg::MAX_ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  wtcm_pkg::cfg_t  cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  wtcm_pkg::in_t   up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output wtcm_pkg::item_t dn_data
);

  logic [10:0] row_sat;
  logic [15:0] lh;
  logic [26:0] col_prod;
  logic [10:0] col_raw;
  logic [10:0] col_flip;
  logic        flip;
  logic signed [18:0] offset;
  logic [27:0] addr;
  logic        valid;
  wtcm_pkg::item_t data;

  // input clamps
  always_comb begin
    if (int'(up_data.row) >= MAX_ROWS) begin
      row_sat = 11'(MAX_ROWS - 1);
    end else begin
      row_sat = up_data.row;
    end
    lh = (up_data.line_height == 16'd0) ? 16'd1 : up_data.line_height;
  end

  // texture column and mirroring for the facing sides
  always_comb begin
    col_prod = 27'(up_data.wall_frac) * 27'(cfg.tex_width);
    col_raw  = col_prod[26:16];
    flip     = (cfg.tex_width != 11'd0) &&
               ((!up_data.wall_side && up_data.ray_x_positive) ||
                (up_data.wall_side && up_data.ray_y_negative));
    col_flip = flip ? (cfg.tex_width - col_raw - 11'd1) : col_raw;
  end

  // signed row offset and framebuffer address
  always_comb begin
    offset = $signed({8'd0, row_sat}) - $signed({8'd0, cfg.screen_height[11:1]})
           + $signed({4'd0, lh[15:1]});
    addr   = 28'(28'(row_sat) * 28'(cfg.line_bytes))
           + 28'(28'(up_data.column) * 28'(cfg.bytes_per_pixel));
  end

  assign up_ready = !valid || dn_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data.tex_col       <= col_flip[9:0];
      data.pixel_address <= addr;
      data.off_pos       <= (offset > 0) ? offset[15:0] : 16'd0;
      data.line_height   <= lh;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// ----- rtl/wtcm_div_cell.sv -----
// ----------------------------------------------------------------------------
// wtcm_div_cell
// One restoring division cell: yields one quotient bit of the row step.
// ----------------------------------------------------------------------------
module wtcm_div_cell #(
  parameter int QW        = 27,
  parameter int BIT_POS   = 0,
  parameter int FRAC_BITS = wtcm_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      tex_log2,
  input  logic            up_valid,
  output logic            up_ready,
  input  wtcm_pkg::item_t up_data,
  input  logic [15:0]     up_rem,
  input  logic [QW-1:0]   up_quo,
  output logic            dn_valid,
  input  logic            dn_ready,
  output wtcm_pkg::item_t dn_data,
  output logic [15:0]     dn_rem,
  output logic [QW-1:0]   dn_quo
);

  logic        dbit;
  logic [16:0] r_ext;
  logic        ge;
  logic [16:0] r_sub;
  logic        valid;
  wtcm_pkg::item_t data;
  logic [15:0] rem;
  logic [QW-1:0] quo;

  // bring down the dividend bit, the dividend being a single set bit
  always_comb begin
    dbit  = (BIT_POS == int'(tex_log2) + FRAC_BITS);
    r_ext = {up_rem, dbit};
    ge    = r_ext >= {1'b0, up_data.line_height};
    r_sub = ge ? (r_ext - {1'b0, up_data.line_height}) : r_ext;
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= up_data;
      rem  <= r_sub[15:0];
      quo  <= {up_quo[QW-2:0], ge};
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;
  assign dn_rem   = rem;
  assign dn_quo   = quo;

endmodule

// ----- rtl/wtcm_back.sv -----
// ----------------------------------------------------------------------------
// wtcm_back
// Step times offset in split partial products, row mask, texel index.
// ----------------------------------------------------------------------------
module wtcm_back #(
  parameter int QW        = 27,
  parameter int FRAC_BITS = wtcm_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  wtcm_pkg::cfg_t  cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  wtcm_pkg::item_t up_data,
  input  logic [QW-1:0]   up_quo,
  output logic            dn_valid,
  input  logic            dn_ready,
  output wtcm_pkg::out_t  dn_data
);

  // stage 1: partial products
  logic          v1;
  logic          rdy1;
  logic [31:0]   p_lo;
  logic [QW-1:0] p_hi;
  logic [9:0]    col1;
  logic [27:0]   addr1;
  // stage 2: row
  logic          v2;
  logic          rdy2;
  logic [9:0]    row2;
  logic [9:0]    col2;
  logic [27:0]   addr2;
  logic [QW+15:0] prod;
  logic [9:0]    mask;
  // stage 3: output register
  logic          v3;
  logic          rdy3;
  wtcm_pkg::out_t res;
  logic [20:0]   texel;

  assign rdy3     = !v3 || dn_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // partial products of offset and step
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p_lo  <= 32'(up_data.off_pos) * 32'(up_quo[15:0]);
      p_hi  <= QW'(QW'(up_data.off_pos) * QW'(up_quo[QW-1:16]));
      col1  <= up_data.tex_col;
      addr1 <= up_data.pixel_address;
    end
  end

  // recombine, drop the fraction and mask to the texture height
  always_comb begin
    prod = {p_hi, 16'd0} + (QW+16)'(p_lo);
    mask = 10'((11'd1 << cfg.tex_log2) - 11'd1);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      row2  <= prod[FRAC_BITS +: 10] & mask;
      col2  <= col1;
      addr2 <= addr1;
    end
  end

  // texel index into the output register
  assign texel = 21'(21'(row2) * 21'(cfg.tex_width)) + 21'(col2);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      res.tex_col       <= col2;
      res.tex_row       <= row2;
      res.texel_index   <= texel[19:0];
      res.pixel_address <= addr2;
    end
  end

  assign dn_valid = v3;
  assign dn_data  = res;

endmodule

// ----- sim/wall_texture_column_mapper_core_tb.sv -----
// ----------------------------------------------------------------------------
// wall_texture_column_mapper_core_tb
// Self-checking bench: random and directed pixels through the texture mapper,
// results predicted per transaction and compared in order as whole results,
// across several register settings including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wall_texture_column_mapper_core_tb;

  localparam int FRAC_BITS = 16;
  localparam int ROW_LIMIT = 2048;
  localparam int PIPE_LAT  = FRAC_BITS + 15;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  wtcm_pkg::in_t   in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  wtcm_pkg::out_t  out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [2:0]      cfg_index = '0;
  logic [15:0]     cfg_data = '0;

  // mirror of the block registers
  logic [11:0] m_screen_height;
  logic [10:0] m_tex_width;
  logic [3:0]  m_tex_log2;
  logic [15:0] m_line_bytes;
  logic [2:0]  m_bpp;

  wtcm_pkg::in_t  pixel_q[$];
  wtcm_pkg::out_t texel_q[$];
  int   mismatches = 0;
  bit   calm = 1'b0;
  bit   hold_feed = 1'b0;
  bit   in_acc = 1'b0;

  wall_texture_column_mapper_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // texel mapping of one pixel under the current registers
  function automatic wtcm_pkg::out_t map_pixel(wtcm_pkg::in_t p);
    logic [63:0] rw, lh, col, lg, th, stp, tr;
    longint      offs, prod;
    wtcm_pkg::out_t r;
    rw = p.row;
    lh = p.line_height;
    if (rw >= ROW_LIMIT) rw = ROW_LIMIT - 1;
    if (lh == 0) lh = 1;
    col = (64'(p.wall_frac) * m_tex_width) >> 16;
    if (m_tex_width != 0 && ((!p.wall_side && p.ray_x_positive) ||
                             (p.wall_side && p.ray_y_negative)))
      col = 64'(m_tex_width) - col - 1;
    col &= 64'h3FF;
    lg = m_tex_log2;
    if (lg > wtcm_pkg::TEX_LOG2_MAX) lg = wtcm_pkg::TEX_LOG2_MAX;
    th = 64'd1 << lg;
    stp = (th << FRAC_BITS) / lh;
    offs = longint'(rw) - longint'(m_screen_height >> 1) + longint'(lh >> 1);
    prod = offs * longint'(stp);
    if (prod < 0) tr = 0;
    else tr = (64'(prod) >> FRAC_BITS) & (th - 1);
    tr &= 64'h3FF;
    r.tex_col       = col[9:0];
    r.tex_row       = tr[9:0];
    r.texel_index   = 20'(tr * m_tex_width + col);
    r.pixel_address = 28'(rw * m_line_bytes + 64'(p.column) * m_bpp);
    return r;
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_acc) begin
        // hold until accepted
      end else if (pixel_q.size() > 0 && !hold_feed &&
                   (calm || $urandom_range(99) >= 27)) begin
        in_data  <= pixel_q[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= calm || $urandom_range(99) >= 27;
    end
  end

  // prediction on input transaction, checking on result transaction
  always @(posedge clk) begin
    wtcm_pkg::out_t got, want;
    if (!rst) begin
      in_acc = in_valid && in_ready;
      if (in_valid && in_ready) begin
        texel_q.push_back(map_pixel(pixel_q.pop_front()));
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (texel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = texel_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  task automatic drain();
    while (pixel_q.size() > 0 || in_valid || texel_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(wtcm_pkg::cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wtcm_pkg::CFG_SCREEN_HEIGHT:   m_screen_height = val[11:0];
      wtcm_pkg::CFG_TEX_WIDTH:       m_tex_width     = val[10:0];
      wtcm_pkg::CFG_TEX_HEIGHT_LOG2: m_tex_log2      = val[3:0];
      wtcm_pkg::CFG_LINE_BYTES:      m_line_bytes    = val;
      wtcm_pkg::CFG_BYTES_PER_PIXEL: m_bpp           = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic wtcm_pkg::in_t rand_pixel();
    wtcm_pkg::in_t p;
    p = wtcm_pkg::in_t'($bits(wtcm_pkg::in_t)'({$urandom, $urandom}));
    // mostly realistic slice heights and rows, sometimes anything
    if ($urandom_range(3) != 0) begin
      p.line_height = $urandom_range(1, 1200);
      p.row         = $urandom_range(0, 1100);
    end
    if ($urandom_range(40) == 0) p.line_height = 0;
    return p;
  endfunction

  initial begin
    wtcm_pkg::in_t p;
    m_screen_height = 12'd480;
    m_tex_width     = 11'd64;
    m_tex_log2      = 4'd6;
    m_line_bytes    = 16'd2560;
    m_bpp           = 3'd4;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, flips, zero height, negative offsets
    for (int i = 0; i < 16; i++) begin
      p = '0;
      p.row            = (i & 1) ? 11'h7FF : 11'd0;
      p.column         = (i & 2) ? 12'hFFF : 12'd0;
      p.wall_frac      = (i & 4) ? 16'hFFFF : 16'd0;
      p.wall_side      = i[0];
      p.ray_x_positive = i[1];
      p.ray_y_negative = i[2];
      p.line_height    = (i & 8) ? 16'hFFFF : (i & 1) ? 16'd1 : 16'd0;
      pixel_q.push_back(p);
    end
    p = '0; p.row = 11'd10; p.line_height = 16'd20;   // negative texture row
    pixel_q.push_back(p);
    p.row = 11'd240; p.line_height = 16'd64; p.wall_frac = 16'h8000;
    p.ray_x_positive = 1'b1;
    pixel_q.push_back(p);

    // sender held back part way until the pipe is empty
    while (pixel_q.size() > 9) @(posedge clk);
    hold_feed = 1'b1;
    while (texel_q.size() > 0 || in_valid) @(posedge clk);
    hold_feed = 1'b0;
    drain();

    // settings: minimum, maximum, odd cases, random, reset-like
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(wtcm_pkg::CFG_SCREEN_HEIGHT, 16'd1);
          write_reg(wtcm_pkg::CFG_TEX_WIDTH, 16'd1);
          write_reg(wtcm_pkg::CFG_TEX_HEIGHT_LOG2, 16'd0);
          write_reg(wtcm_pkg::CFG_LINE_BYTES, 16'd1);
          write_reg(wtcm_pkg::CFG_BYTES_PER_PIXEL, 16'd1);
        end
        1: begin
          write_reg(wtcm_pkg::CFG_SCREEN_HEIGHT, 16'hFFFF);
          write_reg(wtcm_pkg::CFG_TEX_WIDTH, 16'hFFFF);
          write_reg(wtcm_pkg::CFG_TEX_HEIGHT_LOG2, 16'hFFFF);
          write_reg(wtcm_pkg::CFG_LINE_BYTES, 16'hFFFF);
          write_reg(wtcm_pkg::CFG_BYTES_PER_PIXEL, 16'hFFFF);
        end
        2: begin
          write_reg(wtcm_pkg::CFG_SCREEN_HEIGHT, 16'd0);
          write_reg(wtcm_pkg::CFG_TEX_WIDTH, 16'd0);
          write_reg(wtcm_pkg::CFG_TEX_HEIGHT_LOG2, 16'd10);
          write_reg(wtcm_pkg::CFG_LINE_BYTES, 16'd0);
          write_reg(wtcm_pkg::CFG_BYTES_PER_PIXEL, 16'd0);
        end
        3: begin
          write_reg(wtcm_pkg::CFG_SCREEN_HEIGHT, 16'd2048);
          write_reg(wtcm_pkg::CFG_TEX_WIDTH, 16'd1024);
          write_reg(wtcm_pkg::CFG_TEX_HEIGHT_LOG2, 16'd11);
          write_reg(wtcm_pkg::CFG_LINE_BYTES, 16'd65535);
          write_reg(wtcm_pkg::CFG_BYTES_PER_PIXEL, 16'd4);
          // unknown register, ignored
          write_reg(wtcm_pkg::cfg_index_t'(3'd7), 16'd5);
        end
        4: begin
          write_reg(wtcm_pkg::CFG_SCREEN_HEIGHT, 16'($urandom_range(1, 2048)));
          write_reg(wtcm_pkg::CFG_TEX_WIDTH, 16'($urandom_range(1, 1024)));
          write_reg(wtcm_pkg::CFG_TEX_HEIGHT_LOG2, 16'($urandom_range(0, 10)));
          write_reg(wtcm_pkg::CFG_LINE_BYTES, 16'($urandom_range(1, 65535)));
          write_reg(wtcm_pkg::CFG_BYTES_PER_PIXEL, 16'($urandom_range(5, 7)));
        end
        default: begin
          write_reg(wtcm_pkg::CFG_SCREEN_HEIGHT, 16'd480);
          write_reg(wtcm_pkg::CFG_TEX_WIDTH, 16'd64);
          write_reg(wtcm_pkg::CFG_TEX_HEIGHT_LOG2, 16'd6);
          write_reg(wtcm_pkg::CFG_LINE_BYTES, 16'd2560);
          write_reg(wtcm_pkg::CFG_BYTES_PER_PIXEL, 16'd4);
        end
      endcase
      // last phase runs with no idling on either side
      calm = (ph == 5);
      for (int n = 0; n < 216; n++) pixel_q.push_back(rand_pixel());
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wtcm_pkg.sv
rtl/wtcm_front.sv
rtl/wtcm_div_cell.sv
rtl/wtcm_back.sv
rtl/wall_texture_column_mapper_core.sv
sim/wall_texture_column_mapper_core_tb.sv
